@@ hdl/led_bcs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink-code sequencer package
// Shared types and constants: configuration bundle, symbol codes, widths.
// ----------------------------------------------------------------------------
package led_bcs_pkg;

  localparam int unsigned CodeHalfW = 32;
  localparam int unsigned TickW     = 8;
  localparam int unsigned SymW      = 4;
  localparam int unsigned PosW      = 5;
  localparam int unsigned CfgIdxW   = 3;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] CFG_CODE_LO    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CODE_HI    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_GAP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_GAP  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DIGIT_GAP  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_FLASH = 3'd5;

  // reset values of the configuration registers
  localparam logic [CodeHalfW-1:0] CODE_LO_RST    = 32'h31B0_1B52;
  localparam logic [CodeHalfW-1:0] CODE_HI_RST    = 32'hFF13_B81A;
  localparam logic [TickW-1:0]     LONG_GAP_RST   = 8'd36;
  localparam logic [TickW-1:0]     SHORT_GAP_RST  = 8'd20;
  localparam logic [TickW-1:0]     DIGIT_GAP_RST  = 8'd12;
  localparam logic [TickW-1:0]     ZERO_FLASH_RST = 8'd50;

  // symbol codes
  localparam logic [SymW-1:0] SYM_ZERO      = 4'd0;
  localparam logic [SymW-1:0] SYM_LONG_GAP  = 4'd10;
  localparam logic [SymW-1:0] SYM_SHORT_GAP = 4'd11;
  localparam logic [SymW-1:0] SYM_END       = 4'd15;

  // lead-in flash
  localparam logic [TickW-1:0] LEAD_COUNT   = 8'd15;
  localparam logic [TickW-1:0] LEAD_DARK_AT = 8'd6;

  typedef struct packed {
    logic [2*CodeHalfW-1:0] code;        // {high half, low half}
    logic [TickW-1:0]       long_gap;
    logic [TickW-1:0]       short_gap;
    logic [TickW-1:0]       digit_gap;
    logic [TickW-1:0]       zero_flash;
  } cfg_t;

endpackage
`default_nettype wire

@@ hdl/led_bcs_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink-code configuration registers
// Register file written through the configuration channel.
// ----------------------------------------------------------------------------
module led_bcs_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [led_bcs_pkg::CfgIdxW-1:0]     wr_index_i,
  input  wire logic [led_bcs_pkg::CodeHalfW-1:0]   wr_data_i,
  output led_bcs_pkg::cfg_t                        cfg_o
);

  logic [led_bcs_pkg::CodeHalfW-1:0] code_lo_q, code_hi_q;
  logic [led_bcs_pkg::TickW-1:0]     long_gap_q, short_gap_q, digit_gap_q, zero_flash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_lo_q    <= led_bcs_pkg::CODE_LO_RST;
      code_hi_q    <= led_bcs_pkg::CODE_HI_RST;
      long_gap_q   <= led_bcs_pkg::LONG_GAP_RST;
      short_gap_q  <= led_bcs_pkg::SHORT_GAP_RST;
      digit_gap_q  <= led_bcs_pkg::DIGIT_GAP_RST;
      zero_flash_q <= led_bcs_pkg::ZERO_FLASH_RST;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        led_bcs_pkg::CFG_CODE_LO:    code_lo_q    <= wr_data_i;
        led_bcs_pkg::CFG_CODE_HI:    code_hi_q    <= wr_data_i;
        led_bcs_pkg::CFG_LONG_GAP:   long_gap_q   <= wr_data_i[led_bcs_pkg::TickW-1:0];
        led_bcs_pkg::CFG_SHORT_GAP:  short_gap_q  <= wr_data_i[led_bcs_pkg::TickW-1:0];
        led_bcs_pkg::CFG_DIGIT_GAP:  digit_gap_q  <= wr_data_i[led_bcs_pkg::TickW-1:0];
        led_bcs_pkg::CFG_ZERO_FLASH: zero_flash_q <= wr_data_i[led_bcs_pkg::TickW-1:0];
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  assign cfg_o = '{code:       {code_hi_q, code_lo_q},
                   long_gap:   long_gap_q,
                   short_gap:  short_gap_q,
                   digit_gap:  digit_gap_q,
                   zero_flash: zero_flash_q};

endmodule
`default_nettype wire

@@ hdl/led_bcs_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink-code sequencer core
// Phase machine, countdown and symbol pointer; one tick per step.
// ----------------------------------------------------------------------------
module led_bcs_core #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_en_i,
  input  wire logic       start_i,
  input  wire led_bcs_pkg::cfg_t cfg_i,
  output logic            led_o,
  output logic            busy_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_LOAD  = 3'd2;
  localparam logic [2:0] PH_SHOW  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  localparam int unsigned PosW  = led_bcs_pkg::PosW;
  localparam int unsigned TickW = led_bcs_pkg::TickW;
  localparam int unsigned SymW  = led_bcs_pkg::SymW;
  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_SYMBOLS);

  logic [2:0]       phase_q, phase_d, phase_cur;
  logic [TickW-1:0] countdown_q, countdown_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TickW-1:0] zfl_q, zfl_d;
  logic [SymW-1:0]  sym;
  logic             loaded;
  logic             led;

  // positions past the table read as the end mark
  always_comb begin
    if (pos_q >= PosLimit) begin
      sym = led_bcs_pkg::SYM_END;
    end else begin
      sym = cfg_i.code[{pos_q[SymW-1:0], 2'b00} +: SymW];
    end
  end

  always_comb begin
    phase_cur   = phase_q;
    countdown_d = countdown_q;
    pos_d       = pos_q;
    zfl_d       = zfl_q;
    loaded      = 1'b0;
    led         = 1'b0;

    if (start_i && phase_q == PH_IDLE) begin
      phase_cur   = PH_START;
      countdown_d = led_bcs_pkg::LEAD_COUNT;
      loaded      = 1'b1;
    end
    phase_d = phase_cur;

    unique case (phase_cur)
      PH_IDLE: ;
      PH_START: begin
        if (countdown_d > led_bcs_pkg::LEAD_DARK_AT) begin
          led = 1'b1;
        end else if (countdown_d == '0) begin
          pos_d   = '0;
          zfl_d   = '0;
          phase_d = PH_LOAD;
        end
      end
      PH_LOAD: begin
        if (sym == led_bcs_pkg::SYM_LONG_GAP || sym == led_bcs_pkg::SYM_SHORT_GAP) begin
          countdown_d = (sym == led_bcs_pkg::SYM_LONG_GAP) ? cfg_i.long_gap : cfg_i.short_gap;
          loaded      = 1'b1;
          phase_d     = PH_WAIT;
        end else if (sym == led_bcs_pkg::SYM_END) begin
          phase_d = PH_IDLE;
        end else begin
          if (sym == led_bcs_pkg::SYM_ZERO) begin
            zfl_d = cfg_i.zero_flash;
          end else begin
            // 4n-1
            countdown_d = {2'b00, sym - 4'd1, 2'b11};
            loaded      = 1'b1;
          end
          phase_d = PH_SHOW;
        end
        pos_d = pos_q + 1'b1;
      end
      PH_SHOW: begin
        if (zfl_q != '0) begin
          zfl_d = zfl_q - 1'b1;
          led   = 1'b1;
        end else if (countdown_d == '0) begin
          countdown_d = cfg_i.digit_gap;
          loaded      = 1'b1;
          phase_d     = PH_WAIT;
        end else if (countdown_d[1]) begin
          led = 1'b1;
        end
      end
      PH_WAIT: begin
        if (countdown_d == '0) begin
          phase_d = (sym == led_bcs_pkg::SYM_END) ? PH_IDLE : PH_LOAD;
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    if (!loaded && countdown_d != '0) begin
      countdown_d = countdown_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      countdown_q <= '0;
      pos_q       <= '0;
      zfl_q       <= '0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      countdown_q <= countdown_d;
      pos_q       <= pos_d;
      zfl_q       <= zfl_d;
    end
  end

  assign led_o  = led;
  assign busy_o = (phase_d != PH_IDLE);

  // zero flash counter only runs inside the show phase
  a_zfl_in_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zfl_q != '0 |-> phase_q == PH_SHOW)
    else $error("zero flash count live outside show phase");

  // a symbol is only fetched from inside the table
  a_load_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LOAD |-> pos_q < PosLimit)
    else $error("load phase with position past the table");

  // a held core does not move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(phase_q) && $stable(countdown_q) && $stable(pos_q))
    else $error("core state changed without a step");

endmodule
`default_nettype wire

@@ hdl/led_blink_code_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED blink-code sequencer
// Plays a configured digit code on one LED, one input transfer per tick.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[0] start_request
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[0] led_on, [1] busy_res
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
//  One result per input transfer; the item passes the input register, then
//  the result register, before the result is valid; one transfer per cycle
//  sustained while m_axis is ready.
//  The phase/countdown update is a single pass of logic in the core.
//  Reset clears the input/result valids, the core state and restores the
//  configuration defaults. The configuration channel is always ready.
//  A stalled m_axis holds its result; the input register keeps accepting
//  until it holds one waiting item.
// ----------------------------------------------------------------------------
module led_blink_code_sequencer #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] start_request, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] led_on, [1] busy_res, [7:2] zero
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [led_bcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [led_bcs_pkg::CodeHalfW-1:0] cfg_data_i
);

  led_bcs_pkg::cfg_t cfg;

  logic in_vld_q, in_vld_d, in_start_q;
  logic out_vld_q, out_vld_d, out_led_q, out_busy_q;
  logic out_free, step, in_take;
  logic led, busy;

  assign cfg_ready_o = 1'b1;

  led_bcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
  assign out_vld_d = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);

  led_bcs_core #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step),
    .start_i   (in_start_q),
    .cfg_i     (cfg),
    .led_o     (led),
    .busy_o    (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_start_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_led_q  <= led;
      out_busy_q <= busy;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_busy_q, out_led_q};

  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("processed item produced no result");

  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
`default_nettype wire
